/* src/pd_pkg.sv */
// Shared types, constants and helper functions for the percent decoder.
// Used by pd_front, pd_queue, pd_back and percent_decoder.
`timescale 1ns / 1ps
`default_nettype none

package pd_pkg;

    localparam logic [7:0] PCT_CHAR       = 8'h25;
    localparam int         PD_QUEUE_DEPTH = 4;

    // One classified input item: up to three output bytes, emitted in slot order.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       last;
    } pd_rec_t;

    function automatic logic hex_valid(input logic [7:0] c);
        hex_valid = (c >= 8'h30 && c <= 8'h39) ||
                    (c >= 8'h41 && c <= 8'h46) ||
                    (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/percent_decoder.sv */
// Streaming URL percent decoder, one string byte per transfer.
// Both channels behave as queues. Input: drive in_byte and in_last with
// push high; the byte transfers at a clock edge where full is low. Output:
// while empty is low, out_byte and out_last show the oldest decoded byte;
// it transfers at an edge where pop is high.
// A '%' with two hex digits yields one byte; broken escapes are flushed raw
// with the '%' and the held digit, and out_last marks the final output byte
// of a string. Bytes that open an escape produce nothing until resolved.
// A byte that produces output goes as a record into the queue, then into
// the back end's output register. Throughput: one input byte per cycle
// while full is low; the output side gives one byte per cycle while pop is
// high, so inputs that expand to two or three bytes drain through the
// record queue between front and back end (QUEUE_DEPTH records).
// When the receiver stalls, the queue fills and full rises; nothing is lost.
// Reset clears the escape state, the queue and the output stage.
// Depends on pd_pkg, pd_front, pd_queue and pd_back.
`timescale 1ns / 1ps
`default_nettype none

module percent_decoder
    import pd_pkg::*;
#(
    parameter int QUEUE_DEPTH = PD_QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    pd_rec_t front_rec;
    pd_rec_t q_data;
    logic    front_valid;
    logic    accept;
    logic    q_full;
    logic    q_nonempty;
    logic    q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    pd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .rec       (front_rec),
        .rec_valid (front_valid)
    );

    pd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_valid),
        .wr_data  (front_rec),
        .rd_en    (q_pop),
        .rd_data  (q_data),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    pd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_data),
        .q_nonempty (q_nonempty),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule

`default_nettype wire

/* src/pd_front.sv */
// Front end of the percent decoder: tracks the escape state and turns each
// accepted input byte into at most one record of output bytes. Depends on pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_front
    import pd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output pd_rec_t         rec,
    output logic            rec_valid
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       hv;
    logic       is_pct;

    always_comb
    begin
        hv         = hex_valid(in_byte);
        is_pct     = (in_byte == PCT_CHAR) && !in_last;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        rec.count  = 2'd0;
        rec.b0     = PCT_CHAR;
        rec.b1     = in_byte;
        rec.b2     = in_byte;
        rec.last   = in_last;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (hv && !in_last)
                begin
                    held_next  = in_byte;
                    phase_next = PH_DIGIT;
                end
                else if (!hv && is_pct)
                begin
                    rec.count  = 2'd1;
                    phase_next = PH_PCT;
                end
                else
                begin
                    rec.count = 2'd2;
                end
            end
            PH_DIGIT:
            begin
                if (hv)
                begin
                    rec.count = 2'd1;
                    rec.b0    = {hex_nibble(held_reg), hex_nibble(in_byte)};
                end
                else
                begin
                    rec.b1 = held_reg;
                    if (is_pct)
                    begin
                        rec.count  = 2'd2;
                        phase_next = PH_PCT;
                    end
                    else
                    begin
                        rec.count = 2'd3;
                    end
                end
            end
            default:
            begin
                if (is_pct)
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    rec.count = 2'd1;
                    rec.b0    = in_byte;
                end
            end
        endcase
        rec_valid = accept && (rec.count != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

/* src/pd_queue.sv */
// Small register queue of classified records between front and back end.
// Depends on pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_queue
    import pd_pkg::*;
#(
    parameter int DEPTH = PD_QUEUE_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire pd_rec_t wr_data,
    input  wire logic    rd_en,
    output pd_rec_t      rd_data,
    output logic         full,
    output logic         nonempty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pd_rec_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == FULL_CNT);
    assign nonempty = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* src/pd_back.sv */
// Back end of the percent decoder: holds one record and hands out its bytes
// one transfer at a time. Depends on pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_back
    import pd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire pd_rec_t    q_data,
    input  wire logic       q_nonempty,
    output logic            q_pop,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    pd_rec_t    rec_reg, rec_next;
    logic       valid_reg, valid_next;
    logic [1:0] pos_reg, pos_next;
    logic       at_end;
    logic       take;

    always_comb
    begin
        at_end = (pos_reg == rec_reg.count - 2'd1);
        take   = valid_reg && pop;
        q_pop  = q_nonempty && (!valid_reg || (take && at_end));

        rec_next   = rec_reg;
        valid_next = valid_reg;
        pos_next   = pos_reg;
        if (q_pop)
        begin
            rec_next   = q_data;
            valid_next = 1'b1;
            pos_next   = 2'd0;
        end
        else if (take)
        begin
            if (at_end)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end

        unique case (pos_reg)
            2'd0:    out_byte = rec_reg.b0;
            2'd1:    out_byte = rec_reg.b1;
            default: out_byte = rec_reg.b2;
        endcase
        out_last = rec_reg.last && at_end;
        empty    = !valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

`default_nettype wire

/* tb/percent_decoder_tb.sv */
// Self-checking testbench for percent_decoder: a directed table, then random strings
// checked against a behavioral decoder model, with random idling on both queue sides.
// Depends on pd_pkg and the percent_decoder RTL.
`timescale 1ns / 1ps

module percent_decoder_tb;
    import pd_pkg::*;

    localparam int RANDOM_ITEMS = 470;
    localparam int MAX_WAIT     = 6;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {ESC_IDLE, ESC_PCT, ESC_DIGIT} esc_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [1:0] count;
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] in_byte;
    logic       in_last;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       out_last;

    esc_phase_t esc_phase;
    logic [7:0] held_digit;
    dec_byte_t  decoded_q[$];
    int         errors;
    int         idle_cycles;

    stim_row_t  directed_rows [0:25];

    percent_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .out_last (out_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic int hex_value(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
        begin
            return int'(c) - 'h30;
        end
        if (c inside {[8'h41:8'h46]})
        begin
            return int'(c) - 'h41 + 10;
        end
        if (c inside {[8'h61:8'h66]})
        begin
            return int'(c) - 'h61 + 10;
        end
        return -1;
    endfunction

    function automatic logic [7:0] random_hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
        begin
            return 8'(8'h30 + r);
        end
        if (r < 16)
        begin
            return 8'(8'h41 + r - 10);
        end
        return 8'(8'h61 + r - 16);
    endfunction

    // Advances the decoder state by one input byte and returns the bytes it releases.
    function automatic int decode_step(input logic [7:0] b, input logic l,
                                       output dec_byte_t res [3]);
        int n;
        int lo;
        int hi;
        n = 0;
        lo = hex_value(b);
        res[0] = '0;
        res[1] = '0;
        res[2] = '0;
        case (esc_phase)
            ESC_PCT:
            begin
                if (lo >= 0 && !l)
                begin
                    held_digit = b;
                    esc_phase = ESC_DIGIT;
                end
                else if (lo >= 0)
                begin
                    res[0] = {PCT_CHAR, 1'b0};
                    res[1] = {b, 1'b1};
                    n = 2;
                    esc_phase = ESC_IDLE;
                end
                else
                begin
                    res[0] = {PCT_CHAR, 1'b0};
                    n = 1;
                    if (b == PCT_CHAR && !l)
                    begin
                        esc_phase = ESC_PCT;
                    end
                    else
                    begin
                        res[1] = {b, l};
                        n = 2;
                        esc_phase = ESC_IDLE;
                    end
                end
            end
            ESC_DIGIT:
            begin
                if (lo >= 0)
                begin
                    hi = hex_value(held_digit);
                    res[0] = {hi[3:0], lo[3:0], l};
                    n = 1;
                    esc_phase = ESC_IDLE;
                end
                else
                begin
                    res[0] = {PCT_CHAR, 1'b0};
                    res[1] = {held_digit, 1'b0};
                    n = 2;
                    if (b == PCT_CHAR && !l)
                    begin
                        esc_phase = ESC_PCT;
                    end
                    else
                    begin
                        res[2] = {b, l};
                        n = 3;
                        esc_phase = ESC_IDLE;
                    end
                end
            end
            default:
            begin
                if (b == PCT_CHAR && !l)
                begin
                    esc_phase = ESC_PCT;
                end
                else
                begin
                    res[0] = {b, l};
                    n = 1;
                    esc_phase = ESC_IDLE;
                end
            end
        endcase
        return n;
    endfunction

    function automatic void queue_decoded(input logic [7:0] b, input logic l);
        dec_byte_t res [3];
        int n;
        n = decode_step(b, l, res);
        for (int k = 0; k < n; k++)
        begin
            decoded_q.push_back(res[k]);
        end
    endfunction

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l, input int gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        in_last <= l;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic send_string(input logic [7:0] str[$], input logic fast);
        for (int i = 0; i < str.size(); i++)
        begin
            send_byte(str[i], i == str.size() - 1, fast ? 0 : $urandom_range(0, MAX_WAIT));
            queue_decoded(str[i], i == str.size() - 1);
        end
    endtask

    initial
    begin
        logic [7:0] str[$];
        dec_byte_t  res [3];
        stim_row_t  row;
        int         sent;
        int         units;
        int         kind;
        logic       paused;

        directed_rows = '{
            '{8'h41, 1'b0, 1'b1, 2'd1, 8'h41, 8'h00, 8'h00},
            '{8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
            '{8'hFF, 1'b1, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00},
            '{8'h25, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h30, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h39, 1'b0, 1'b1, 2'd1, 8'h09, 8'h00, 8'h00},
            '{8'h25, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h66, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h46, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00},
            '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h61, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h41, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h47, 1'b0, 1'b1, 2'd2, 8'h25, 8'h47, 8'h00},
            '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h25, 1'b0, 1'b1, 2'd1, 8'h25, 8'h00, 8'h00},
            '{8'h34, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h5A, 1'b1, 1'b1, 2'd2, 8'h25, 8'h5A, 8'h00},
            '{8'h25, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h34, 1'b1, 1'b1, 2'd2, 8'h25, 8'h34, 8'h00},
            '{8'h25, 1'b1, 1'b1, 2'd1, 8'h25, 8'h00, 8'h00},
            '{8'h25, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h34, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
            '{8'h78, 1'b1, 1'b1, 2'd3, 8'h25, 8'h34, 8'h78},
            '{8'h3A, 1'b1, 1'b1, 2'd1, 8'h3A, 8'h00, 8'h00}
        };

        esc_phase  = ESC_IDLE;
        held_digit = 8'h00;
        errors     = 0;
        rst_n      = 1'b0;
        push       = 1'b0;
        in_byte    = 8'h00;
        in_last    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(directed_rows); i++)
        begin
            row = directed_rows[i];
            send_byte(row.data, row.last, $urandom_range(0, MAX_WAIT));
            if (row.typed)
            begin
                void'(decode_step(row.data, row.last, res));
                if (row.count > 0)
                begin
                    decoded_q.push_back({row.e0, row.last && row.count == 1});
                end
                if (row.count > 1)
                begin
                    decoded_q.push_back({row.e1, row.last && row.count == 2});
                end
                if (row.count > 2)
                begin
                    decoded_q.push_back({row.e2, row.last});
                end
            end
            else
            begin
                queue_decoded(row.data, row.last);
            end
        end

        wait_drained();

        sent = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            str.delete();
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 8)) str.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                units = $urandom_range(1, 6);
                for (int u = 0; u < units; u++)
                begin
                    kind = $urandom_range(0, 9);
                    if (kind <= 3)
                    begin
                        str.push_back(PCT_CHAR);
                        str.push_back(random_hex_char());
                        str.push_back(random_hex_char());
                    end
                    else if (kind <= 5)
                    begin
                        str.push_back(8'($urandom_range(0, 255)));
                    end
                    else if (kind == 6)
                    begin
                        str.push_back(PCT_CHAR);
                        str.push_back($urandom_range(0, 1) ? PCT_CHAR : 8'($urandom_range(0, 255)));
                    end
                    else if (kind == 7)
                    begin
                        str.push_back(PCT_CHAR);
                        str.push_back(random_hex_char());
                        str.push_back($urandom_range(0, 1) ? PCT_CHAR : 8'($urandom_range(0, 255)));
                    end
                    else if (kind == 8)
                    begin
                        str.push_back(PCT_CHAR);
                    end
                    else
                    begin
                        str.push_back(random_hex_char());
                    end
                end
            end
            send_string(str, $urandom_range(0, 3) == 0);
            sent += str.size();
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
        end

        push <= 1'b0;
        while (decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && decoded_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        dec_byte_t want;
        logic      quiet;
        int        gap;

        pop   = 1'b0;
        quiet = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                quiet = !quiet;
            end
            gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
            begin
                @(posedge clk);
            end
            if (decoded_q.size() == 0)
            begin
                flag_error($sformatf("unexpected transfer: out_byte=%02h out_last=%0b",
                                     out_byte, out_last));
            end
            else
            begin
                want = decoded_q.pop_front();
                if (out_byte !== want.data)
                begin
                    flag_error($sformatf("out_byte mismatch: expected %02h, got %02h",
                                         want.data, out_byte));
                end
                if (out_last !== want.last)
                begin
                    flag_error($sformatf("out_last mismatch: expected %0b, got %0b",
                                         want.last, out_last));
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
